// ----- src/vtol_transition_mode_sequencer_defines.svh -----
// assertion macros shared by the vtol transition sequencer rtl
`ifndef VTOL_TRANSITION_MODE_SEQUENCER_DEFINES_SVH
`define VTOL_TRANSITION_MODE_SEQUENCER_DEFINES_SVH

// antecedent in a cycle implies consequent in the same cycle
`define VTC_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be true
`define VTC_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ----- src/vtc_pkg.sv -----
// types and constants of the vtol transition mode sequencer
`default_nettype none
package vtc_pkg;

    typedef enum logic [2:0] {
        PH_MC   = 3'd0,
        PH_P1   = 3'd1,
        PH_P2   = 3'd2,
        PH_FW   = 3'd3,
        PH_BACK = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MODE_ROTARY = 2'd0,
        MODE_FW     = 2'd1,
        MODE_TO_FW  = 2'd2,
        MODE_TO_MC  = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [2:0] CFG_TILT_MC       = 3'd0;
    localparam logic [2:0] CFG_TILT_TRANS    = 3'd1;
    localparam logic [2:0] CFG_TILT_FW       = 3'd2;
    localparam logic [2:0] CFG_BACK_DUR      = 3'd3;
    localparam logic [2:0] CFG_FRONT_MIN     = 3'd4;
    localparam logic [2:0] CFG_FRONT_OPEN    = 3'd5;
    localparam logic [2:0] CFG_SWITCH_AS     = 3'd6;
    localparam logic [2:0] CFG_AIRSPEED_OFF  = 3'd7;

    localparam int TIME_W = 48;
    localparam int DUR_W  = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic signed [15:0] tilt_multicopter;
        logic signed [15:0] tilt_handover;
        logic signed [15:0] tilt_fixed_wing;
        logic [DUR_W-1:0]   back_duration_us;
        logic [DUR_W-1:0]   front_min_time_us;
        logic [DUR_W-1:0]   front_openloop_time_us;
        logic [15:0]        switch_airspeed;
        logic               airspeed_off;
    } cfg_t;

    typedef struct packed {
        logic               ground_ok;
        logic [15:0]        airspeed;
        logic               airspeed_ok;
        logic signed [15:0] tilt_now;
        logic               fw_requested;
        logic [TIME_W-1:0]  now_us;
    } item_t;

    typedef struct packed {
        logic   force_tilt_fw;
        mode_t  simple_mode;
        phase_t phase;
    } result_t;

endpackage
`default_nettype wire

// ----- src/vtol_transition_mode_sequencer.sv -----
// top level of the vtol transition mode sequencer
// Takes one control tick per clock cycle while m_ does not stall and returns one
// result per tick: the tick lands in an input register, the phase decision (one
// 48-bit subtract for the elapsed time and a few compares) runs between that
// register and the result register, and the phase and start time state closes its
// loop through that decision as each tick moves on into the result register.
// Backpressure on m_ stalls both stages; s_tready stays high while the input
// register is empty or its tick moves on into the result register.
// Configuration writes are always taken (cfg_ready is high) and should be done
// while no tick is in flight.
`default_nettype none
`include "vtol_transition_mode_sequencer_defines.svh"
module vtol_transition_mode_sequencer
    import vtc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // now_us[47:0], fw_requested[48], tilt_now[64:49], airspeed_ok[65],
    // airspeed[81:66], ground_ok[82], zero[87:83]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // phase[2:0], simple_mode[4:3], force_tilt_fw[5], zero[7:6]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    s_accept;

    assign cfg_ready = 1'b1;

    vtc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_tdata[$bits(item_t)-1:0];
        end
    end

    vtc_phase_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_res_reg};

    // checks on the result and pipeline
    `VTC_ASSERT_IMPLIES(a_force_only_fw, aclk, aresetn,
        m_tvalid && out_res_reg.force_tilt_fw, out_res_reg.phase == PH_FW,
        "force_tilt_fw set outside fixed-wing phase")
    `VTC_ASSERT_IMPLIES(a_mode_matches_fw, aclk, aresetn,
        m_tvalid && out_res_reg.phase == PH_FW, out_res_reg.simple_mode == MODE_FW,
        "simple mode does not match fixed-wing phase")
    `VTC_ASSERT_NEVER(a_no_advance_blocked, aclk, aresetn,
        advance && out_valid_reg && !m_tready,
        "tick advanced into an occupied result register")

endmodule
`default_nettype wire

// ----- src/vtc_cfg_regs.sv -----
// configuration register file of the transition sequencer
`default_nettype none
module vtc_cfg_regs
    import vtc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the register write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_TILT_MC:      cfg_next.tilt_multicopter       = wr_data[15:0];
                CFG_TILT_TRANS:   cfg_next.tilt_handover          = wr_data[15:0];
                CFG_TILT_FW:      cfg_next.tilt_fixed_wing        = wr_data[15:0];
                CFG_BACK_DUR:     cfg_next.back_duration_us       = wr_data[DUR_W-1:0];
                CFG_FRONT_MIN:    cfg_next.front_min_time_us      = wr_data[DUR_W-1:0];
                CFG_FRONT_OPEN:   cfg_next.front_openloop_time_us = wr_data[DUR_W-1:0];
                CFG_SWITCH_AS:    cfg_next.switch_airspeed        = wr_data[15:0];
                CFG_AIRSPEED_OFF: cfg_next.airspeed_off           = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register file with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tilt_multicopter       <= 16'sd0;
            cfg_reg.tilt_handover          <= 16'sd4096;
            cfg_reg.tilt_fixed_wing        <= 16'sd16384;
            cfg_reg.back_duration_us       <= 26'd4000000;
            cfg_reg.front_min_time_us      <= 26'd2000000;
            cfg_reg.front_openloop_time_us <= 26'd6000000;
            cfg_reg.switch_airspeed        <= 16'd1000;
            cfg_reg.airspeed_off           <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- src/vtc_phase_core.sv -----
// flight phase state and per-tick transition decision
`default_nettype none
module vtc_phase_core
    import vtc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   res
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [TIME_W-1:0]   start_time_reg;
    logic [TIME_W-1:0]   start_time_next;
    logic [TIME_W-1:0]   elapsed;
    logic                back_done;
    logic                min_done;
    logic                open_done;
    logic                go;
    logic                force_fw;
    mode_t               mode;

    // elapsed time wraps modulo 2^48
    assign elapsed   = item.now_us - start_time_reg;
    assign back_done = elapsed > {{(TIME_W-DUR_W){1'b0}}, cfg.back_duration_us};
    assign min_done  = elapsed > {{(TIME_W-DUR_W){1'b0}}, cfg.front_min_time_us};
    assign open_done = elapsed > {{(TIME_W-DUR_W){1'b0}}, cfg.front_openloop_time_us};

    // phase one exit: airspeed rule or open-loop rule once minimum time passed
    always_comb begin
        go = 1'b0;
        if (min_done) begin
            if (item.airspeed_ok && !cfg.airspeed_off) begin
                go = item.airspeed >= cfg.switch_airspeed;
            end else begin
                go = (item.tilt_now >= cfg.tilt_handover) && open_done;
            end
        end
    end

    // next phase and start time
    always_comb begin
        phase_next      = PH_MC;
        start_time_next = start_time_reg;
        force_fw        = 1'b0;
        if (!item.fw_requested) begin
            case (phase_reg)
                PH_FW: begin
                    phase_next      = PH_BACK;
                    start_time_next = item.now_us;
                end
                PH_BACK: begin
                    if ((item.tilt_now <= cfg.tilt_multicopter) && back_done) begin
                        phase_next = PH_MC;
                    end else begin
                        phase_next = PH_BACK;
                    end
                end
                default: phase_next = PH_MC;
            endcase
        end else begin
            case (phase_reg)
                PH_P1: begin
                    if (go || item.ground_ok) begin
                        phase_next      = PH_P2;
                        start_time_next = item.now_us;
                    end else begin
                        phase_next = PH_P1;
                    end
                end
                PH_P2: begin
                    if (item.tilt_now >= cfg.tilt_fixed_wing) begin
                        phase_next = PH_FW;
                        force_fw   = 1'b1;
                    end else begin
                        phase_next = PH_P2;
                    end
                end
                PH_FW:   phase_next = PH_FW;
                PH_BACK: phase_next = PH_FW;
                default: begin
                    phase_next      = PH_P1;
                    start_time_next = item.now_us;
                end
            endcase
        end
    end

    // simple mode from the new phase
    always_comb begin
        case (phase_next)
            PH_FW:   mode = MODE_FW;
            PH_P1:   mode = MODE_TO_FW;
            PH_P2:   mode = MODE_TO_FW;
            PH_BACK: mode = MODE_TO_MC;
            default: mode = MODE_ROTARY;
        endcase
    end

    // state advances once per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MC;
            start_time_reg <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            start_time_reg <= start_time_next;
        end
    end

    assign res.phase         = phase_next;
    assign res.simple_mode   = mode;
    assign res.force_tilt_fw = force_fw;

endmodule
`default_nettype wire

// ----- tb/tb_vtol_transition_mode_sequencer.sv -----
// self-checking testbench for the vtol transition mode sequencer
module tb_vtol_transition_mode_sequencer;
    import vtc_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_W       = $bits(item_t);
    localparam int REPORT_W     = $bits(result_t);

    // one directed tick and, where obvious, its expected report
    typedef struct {
        logic [TIME_W-1:0] now;
        bit                req;
        int                tilt;
        bit                as_ok;
        int                as;
        bit                gnd;
        bit                typed;
        phase_t            ph;
        mode_t             md;
        bit                frc;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted sequencer state and register copy
    cfg_t              seq_cfg;
    phase_t            seq_phase;
    logic [TIME_W-1:0] seq_start_us;
    result_t           pending_reports[$];

    // stimulus state
    logic [TIME_W-1:0] sim_now   = '0;
    logic              pilot_req = 1'b0;
    bit                no_idle   = 1'b0;
    bit                hold_ask  = 1'b0;
    int                hold_left = 0;

    int errors       = 0;
    int ticks_sent   = 0;
    int reg_writes   = 0;
    int settings_run = 0;
    int forced_fw    = 0;
    int quiet_cycles = 0;
    int phase_seen[8];

    // columns: now, req, tilt, as_ok, airspeed, ground, typed, phase, mode, force
    dir_row_t dir_rows[25] = '{
        // idle after reset
        '{48'd0,          0,      0, 0,     0, 0, 1, PH_MC,   MODE_ROTARY, 0},
        // request starts front phase one
        '{48'd100,        1,      0, 0,     0, 0, 1, PH_P1,   MODE_TO_FW,  0},
        // top airspeed but too early
        '{48'd200,        1,      0, 1, 65535, 0, 1, PH_P1,   MODE_TO_FW,  0},
        // elapsed exactly the minimum time
        '{48'd2000100,    1,      0, 1, 65535, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // airspeed one below the switch value
        '{48'd2000101,    1,      0, 1,   999, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // airspeed at the switch value
        '{48'd2000102,    1,      0, 1,  1000, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // tilt one short of fixed wing
        '{48'd2000200,    1,  16383, 1,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // tilt at its top completes the transition
        '{48'd2000300,    1,  32767, 0,     0, 0, 1, PH_FW,   MODE_FW,     1},
        // request dropped starts back transition
        '{48'd3000000,    0,      0, 0,     0, 0, 1, PH_BACK, MODE_TO_MC,  0},
        '{48'd3000001,    0, -32768, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // reversed request snaps back to fixed wing
        '{48'd3000002,    1,      0, 0,     0, 0, 1, PH_FW,   MODE_FW,     0},
        '{48'd5000000,    0,      0, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // back duration reached exactly, then tilt too high, then done
        '{48'd9000000,    0,      0, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        '{48'd9000001,    0,      1, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        '{48'd9000002,    0,      0, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        '{48'd1000000000, 1,      0, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // time going backwards passes the open-loop rule
        '{48'd0,          1,   4096, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // reversed request in phase two snaps to multicopter
        '{48'd0,          0,      0, 0,     0, 0, 1, PH_MC,   MODE_ROTARY, 0},
        '{48'hFFFF_FFFF_FFFF, 1,  0, 1,     0, 0, 1, PH_P1,   MODE_TO_FW,  0},
        // ground permission with no elapsed time
        '{48'hFFFF_FFFF_FFFF, 1, -32768, 0, 0, 1, 1, PH_P2,   MODE_TO_FW,  0},
        '{48'd1,          0,      0, 0,     0, 0, 1, PH_MC,   MODE_ROTARY, 0},
        '{48'd10,         1,      0, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // open loop: past minimum but not past open-loop time
        '{48'd3000000,    1,  32767, 0, 65535, 0, 0, PH_MC,   MODE_ROTARY, 0},
        // open loop: time passed but tilt one short
        '{48'd6000011,    1,   4095, 0, 65535, 0, 0, PH_MC,   MODE_ROTARY, 0},
        '{48'd6000011,    1,   4096, 0,     0, 0, 0, PH_MC,   MODE_ROTARY, 0}
    };

    vtol_transition_mode_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // register values and state right after reset
    task automatic load_reset_values();
        seq_cfg.tilt_multicopter       = 16'sd0;
        seq_cfg.tilt_handover          = 16'sd4096;
        seq_cfg.tilt_fixed_wing        = 16'sd16384;
        seq_cfg.back_duration_us       = 26'd4000000;
        seq_cfg.front_min_time_us      = 26'd2000000;
        seq_cfg.front_openloop_time_us = 26'd6000000;
        seq_cfg.switch_airspeed        = 16'd1000;
        seq_cfg.airspeed_off           = 1'b0;
        seq_phase                      = PH_MC;
        seq_start_us                   = '0;
    endtask

    // next flight phase and report for one control tick
    function automatic result_t phase_step(item_t tick);
        logic [TIME_W-1:0]  elapsed;
        logic signed [15:0] tilt;
        phase_t             ph;
        logic               go;
        result_t            rep;
        elapsed = tick.now_us - seq_start_us;
        tilt = $signed(tick.tilt_now);
        ph = seq_phase;
        go = 1'b0;
        rep.force_tilt_fw = 1'b0;
        if (!tick.fw_requested) begin
            case (ph)
                PH_FW: begin
                    ph = PH_BACK;
                    seq_start_us = tick.now_us;
                end
                PH_P1, PH_P2: ph = PH_MC;
                PH_BACK: begin
                    if (tilt <= $signed(seq_cfg.tilt_multicopter)
                            && elapsed > seq_cfg.back_duration_us) begin
                        ph = PH_MC;
                    end
                end
                default: ;
            endcase
        end else begin
            case (ph)
                PH_P1: begin
                    if (elapsed > seq_cfg.front_min_time_us) begin
                        if (tick.airspeed_ok && !seq_cfg.airspeed_off) begin
                            go = tick.airspeed >= seq_cfg.switch_airspeed;
                        end else begin
                            go = tilt >= $signed(seq_cfg.tilt_handover)
                                && elapsed > seq_cfg.front_openloop_time_us;
                        end
                    end
                    if (go || tick.ground_ok) begin
                        ph = PH_P2;
                        seq_start_us = tick.now_us;
                    end
                end
                PH_P2: begin
                    if (tilt >= $signed(seq_cfg.tilt_fixed_wing)) begin
                        ph = PH_FW;
                        rep.force_tilt_fw = 1'b1;
                    end
                end
                PH_BACK: ph = PH_FW;
                PH_FW: ;
                default: begin
                    ph = PH_P1;
                    seq_start_us = tick.now_us;
                end
            endcase
        end
        case (ph)
            PH_FW:        rep.simple_mode = MODE_FW;
            PH_P1, PH_P2: rep.simple_mode = MODE_TO_FW;
            PH_BACK:      rep.simple_mode = MODE_TO_MC;
            default:      rep.simple_mode = MODE_ROTARY;
        endcase
        rep.phase = ph;
        seq_phase = ph;
        return rep;
    endfunction

    // random tick that mostly follows a pilot request held over runs
    function automatic item_t random_tick();
        item_t              tick;
        int                 r;
        int unsigned        span;
        logic [63:0]        wide;
        logic [DUR_W-1:0]   dur;
        logic signed [15:0] base;
        tick = '0;
        span = seq_cfg.back_duration_us;
        if (seq_cfg.front_min_time_us > span) span = seq_cfg.front_min_time_us;
        if (seq_cfg.front_openloop_time_us > span) span = seq_cfg.front_openloop_time_us;
        span = span / 3 + 2;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            // arbitrary jump, often backwards
            wide = {$urandom, $urandom};
            sim_now = wide[TIME_W-1:0];
        end else if (r < 16 && r >= 6) begin
            // land right on a threshold or one past it
            case ($urandom_range(0, 2))
                0:       dur = seq_cfg.back_duration_us;
                1:       dur = seq_cfg.front_min_time_us;
                default: dur = seq_cfg.front_openloop_time_us;
            endcase
            sim_now = seq_start_us + TIME_W'(dur) + TIME_W'($urandom_range(0, 1));
        end else if (r >= 16) begin
            sim_now = sim_now + TIME_W'($urandom_range(0, span));
        end
        tick.now_us = sim_now;

        if ($urandom_range(0, 99) < 8) pilot_req = !pilot_req;
        tick.fw_requested = pilot_req ^ ($urandom_range(0, 99) < 4);

        if ($urandom_range(0, 99) < 20) begin
            tick.tilt_now = 16'($urandom);
        end else begin
            case ($urandom_range(0, 2))
                0:       base = seq_cfg.tilt_multicopter;
                1:       base = seq_cfg.tilt_handover;
                default: base = seq_cfg.tilt_fixed_wing;
            endcase
            tick.tilt_now = base + 16'($urandom_range(0, 2)) - 16'd1;
        end

        tick.airspeed_ok = $urandom_range(0, 99) < 80;
        if ($urandom_range(0, 99) < 30) begin
            tick.airspeed = 16'($urandom);
        end else begin
            tick.airspeed = seq_cfg.switch_airspeed + 16'($urandom_range(0, 2)) - 16'd1;
        end
        tick.ground_ok = $urandom_range(0, 99) < 8;
        return tick;
    endfunction

    // offer one tick, with random idle cycles ahead of it
    task automatic offer_tick(input item_t tick, input bit typed, input result_t want);
        result_t pred;
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-ITEM_W){1'b0}}, tick};
        do @(posedge aclk); while (!s_tready);
        pred = phase_step(tick);
        pending_reports.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    task automatic rest_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_reports_done();
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // one register write request
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TILT_MC:      seq_cfg.tilt_multicopter       = val[15:0];
            CFG_TILT_TRANS:   seq_cfg.tilt_handover          = val[15:0];
            CFG_TILT_FW:      seq_cfg.tilt_fixed_wing        = val[15:0];
            CFG_BACK_DUR:     seq_cfg.back_duration_us       = val[DUR_W-1:0];
            CFG_FRONT_MIN:    seq_cfg.front_min_time_us      = val[DUR_W-1:0];
            CFG_FRONT_OPEN:   seq_cfg.front_openloop_time_us = val[DUR_W-1:0];
            CFG_SWITCH_AS:    seq_cfg.switch_airspeed        = val[15:0];
            CFG_AIRSPEED_OFF: seq_cfg.airspeed_off           = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // write every register while the block is idle
    task automatic program_regs(input logic signed [15:0] tmc, input logic signed [15:0] ttr,
                                input logic signed [15:0] tfw, input logic [DUR_W-1:0] bd,
                                input logic [DUR_W-1:0] fm, input logic [DUR_W-1:0] fo,
                                input logic [15:0] sw, input logic aoff);
        set_reg(CFG_TILT_MC,      CFG_DATA_W'(16'(tmc)));
        set_reg(CFG_TILT_TRANS,   CFG_DATA_W'(16'(ttr)));
        set_reg(CFG_TILT_FW,      CFG_DATA_W'(16'(tfw)));
        set_reg(CFG_BACK_DUR,     bd);
        set_reg(CFG_FRONT_MIN,    fm);
        set_reg(CFG_FRONT_OPEN,   fo);
        set_reg(CFG_SWITCH_AS,    CFG_DATA_W'(sw));
        set_reg(CFG_AIRSPEED_OFF, CFG_DATA_W'(aoff));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 99) >= 31;
        end
    end

    // compare each report with the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[REPORT_W-1:0]);
            if (pending_reports.size() == 0) begin
                $error("report %h with no tick outstanding", m_tdata);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (got.phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, got.phase);
                    errors++;
                end
                if (got.simple_mode !== want.simple_mode) begin
                    $error("simple_mode: expected %0d, got %0d", want.simple_mode,
                           got.simple_mode);
                    errors++;
                end
                if (got.force_tilt_fw !== want.force_tilt_fw) begin
                    $error("force_tilt_fw: expected %0d, got %0d", want.force_tilt_fw,
                           got.force_tilt_fw);
                    errors++;
                end
                phase_seen[int'(want.phase)]++;
                if (want.force_tilt_fw) forced_fw++;
            end
        end
    end

    // count cycles without any accepted request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // main sequence
    initial begin
        item_t              tick;
        result_t            want;
        logic signed [15:0] tmc, ttr, tfw;
        logic [DUR_W-1:0]   bd, fm, fo;
        logic [15:0]        sw;
        logic               aoff;
        int                 count;

        load_reset_values();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed ticks at reset register values
        foreach (dir_rows[i]) begin
            tick              = '0;
            tick.now_us       = dir_rows[i].now;
            tick.fw_requested = dir_rows[i].req;
            tick.tilt_now     = 16'(dir_rows[i].tilt);
            tick.airspeed_ok  = dir_rows[i].as_ok;
            tick.airspeed     = 16'(dir_rows[i].as);
            tick.ground_ok    = dir_rows[i].gnd;
            want.phase         = dir_rows[i].ph;
            want.simple_mode   = dir_rows[i].md;
            want.force_tilt_fw = dir_rows[i].frc;
            offer_tick(tick, dir_rows[i].typed, want);
        end

        // random phases, each under its own register setting
        for (int p = 1; p <= 9; p++) begin
            rest_sender();
            wait_reports_done();
            repeat (DRAIN_CYCLES) @(posedge aclk);
            no_idle = 1'b0;
            case (p)
                1: begin
                    tmc = 16'sd0; ttr = 16'sd4096; tfw = 16'sd16384;
                    bd = 26'd4000000; fm = 26'd2000000; fo = 26'd6000000;
                    sw = 16'd1000; aoff = 1'b0; count = 250;
                end
                2: begin
                    tmc = -16'sd32768; ttr = -16'sd32768; tfw = -16'sd32768;
                    bd = '0; fm = '0; fo = '0; sw = '0; aoff = 1'b0; count = 150;
                end
                3: begin
                    tmc = 16'sd32767; ttr = 16'sd32767; tfw = 16'sd32767;
                    bd = 26'd60000000; fm = 26'd60000000; fo = 26'd60000000;
                    sw = 16'hFFFF; aoff = 1'b1; count = 150;
                end
                default: begin
                    if (p == 9) begin
                        tmc = 16'($urandom); ttr = 16'($urandom); tfw = 16'($urandom);
                    end else begin
                        tmc = 16'($urandom_range(0, 4096)) - 16'sd2048;
                        ttr = tmc + 16'($urandom_range(0, 6000));
                        tfw = ttr + 16'($urandom_range(0, 12000));
                    end
                    if (p == 7) begin
                        bd = DUR_W'($urandom_range(0, 60000000));
                        fm = DUR_W'($urandom_range(0, 60000000));
                        fo = DUR_W'($urandom_range(0, 60000000));
                    end else begin
                        bd = DUR_W'($urandom_range(0, 3000));
                        fm = DUR_W'($urandom_range(0, 3000));
                        fo = DUR_W'($urandom_range(0, 3000));
                    end
                    sw = (p == 8) ? 16'($urandom) : 16'($urandom_range(0, 3000));
                    aoff = (p == 6) ? 1'b1 : 1'($urandom_range(0, 1));
                    count = 170;
                end
            endcase
            program_regs(tmc, ttr, tfw, bd, fm, fo, sw, aoff);
            no_idle = (p == 4);
            for (int n = 0; n < count; n++) begin
                // long receiver hold-off while ticks keep coming
                if (p == 5 && n == 30) hold_ask = 1'b1;
                // sender pause until every report is back
                if (n == count / 2) begin
                    rest_sender();
                    wait_reports_done();
                end
                offer_tick(random_tick(), 1'b0, '0);
            end
        end

        rest_sender();
        wait_reports_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            errors++;
        end

        $display("run: %0d ticks under %0d register settings, %0d register writes",
                 ticks_sent, settings_run + 1, reg_writes);
        $display("reports by phase: mc %0d, front one %0d, front two %0d, fw %0d, back %0d",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4]);
        $display("tilt forced to fixed wing %0d times", forced_fw);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/vtc_pkg.sv
src/vtc_cfg_regs.sv
src/vtc_phase_core.sv
src/vtol_transition_mode_sequencer.sv
tb/tb_vtol_transition_mode_sequencer.sv
